[rtl/core/sdp_pkg.sv]
// shared types and constants for the strict decimal parser
`timescale 1ns / 1ps

package sdp_pkg;

    // character codes
    localparam logic [7:0] CH_NUL   = 8'd0;
    localparam logic [7:0] CH_TAB   = 8'd9;
    localparam logic [7:0] CH_CR    = 8'd13;
    localparam logic [7:0] CH_SPACE = 8'd32;
    localparam logic [7:0] CH_PLUS  = 8'd43;
    localparam logic [7:0] CH_MINUS = 8'd45;
    localparam logic [7:0] CH_ZERO  = 8'd48;
    localparam logic [7:0] CH_NINE  = 8'd57;

    // token kinds produced by the classifier
    localparam logic [2:0] KIND_BLANK = 3'd0;
    localparam logic [2:0] KIND_PLUS  = 3'd1;
    localparam logic [2:0] KIND_MINUS = 3'd2;
    localparam logic [2:0] KIND_DIGIT = 3'd3;
    localparam logic [2:0] KIND_TERM  = 3'd4;
    localparam logic [2:0] KIND_OTHER = 3'd5;

    // largest magnitude that still takes another digit
    localparam logic [31:0] TENTH_LIMIT = 32'd214748364;
    localparam logic [3:0]  LAST_MAX_POS = 4'd7;
    localparam logic [3:0]  LAST_MAX_NEG = 4'd8;

    typedef struct packed {
        logic [2:0] kind;
        logic [3:0] digit;
    } tok_t;

    typedef struct packed {
        logic [31:0] value;
        logic        error;
    } res_t;

endpackage

[rtl/core/sdp_front.sv]
// front end: byte classifier and two-entry token queue
`timescale 1ns / 1ps

module sdp_front (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    output logic          full,
    input  logic [7:0]    ch,
    output sdp_pkg::tok_t tok,
    output logic          tok_valid,
    input  logic          tok_pop
);

    sdp_pkg::tok_t tok_in;
    sdp_pkg::tok_t tok_mem_reg [2];
    logic          wr_ptr_reg;
    logic          wr_ptr_next;
    logic          rd_ptr_reg;
    logic          rd_ptr_next;
    logic [1:0]    cnt_reg;
    logic [1:0]    cnt_next;
    logic          wr_fire;
    logic          rd_fire;

    // classify the incoming byte
    always_comb
    begin
        tok_in.digit = ch[3:0];
        case (ch) inside
            sdp_pkg::CH_NUL:
            begin
                tok_in.kind = sdp_pkg::KIND_TERM;
            end
            [sdp_pkg::CH_TAB:sdp_pkg::CH_CR], sdp_pkg::CH_SPACE:
            begin
                tok_in.kind = sdp_pkg::KIND_BLANK;
            end
            sdp_pkg::CH_PLUS:
            begin
                tok_in.kind = sdp_pkg::KIND_PLUS;
            end
            sdp_pkg::CH_MINUS:
            begin
                tok_in.kind = sdp_pkg::KIND_MINUS;
            end
            [sdp_pkg::CH_ZERO:sdp_pkg::CH_NINE]:
            begin
                tok_in.kind = sdp_pkg::KIND_DIGIT;
            end
            default:
            begin
                tok_in.kind = sdp_pkg::KIND_OTHER;
            end
        endcase
    end

    // queue handshakes
    assign full      = (cnt_reg == 2'd2);
    assign tok_valid = (cnt_reg != 2'd0);
    assign tok       = tok_mem_reg[rd_ptr_reg];
    assign wr_fire   = push && !full;
    assign rd_fire   = tok_pop && tok_valid;

    // pointer and count update
    always_comb
    begin
        wr_ptr_next = wr_fire ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = rd_fire ? ~rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (wr_fire && !rd_fire)
        begin
            cnt_next = cnt_reg + 2'd1;
        end
        else if (rd_fire && !wr_fire)
        begin
            cnt_next = cnt_reg - 2'd1;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // token storage
    always_ff @(posedge clk)
    begin
        if (wr_fire)
        begin
            tok_mem_reg[wr_ptr_reg] <= tok_in;
        end
    end

    // queue occupancy checks
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg != 2'd3)
        else $error("token queue count out of range");

    a_cnt_inc: assert property (@(posedge clk) disable iff (!rst_n)
        wr_fire && !rd_fire |=> cnt_reg == $past(cnt_reg) + 2'd1)
        else $error("token queue count did not grow on write");

    a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg == 2'd0 || cnt_reg == 2'd2) |-> wr_ptr_reg == rd_ptr_reg)
        else $error("token queue pointers inconsistent with count");

endmodule

[rtl/core/sdp_back.sv]
// back end: parse state machine, accumulator and two-entry result queue
`timescale 1ns / 1ps

module sdp_back (
    input  logic               clk,
    input  logic               rst_n,
    input  sdp_pkg::tok_t      tok,
    input  logic               tok_valid,
    output logic               tok_pop,
    output logic               empty,
    input  logic               pop,
    output logic signed [31:0] value,
    output logic               error
);

    localparam logic [1:0] PH_SPACE  = 2'd0;
    localparam logic [1:0] PH_SIGN   = 2'd1;
    localparam logic [1:0] PH_DIGITS = 2'd2;

    logic [1:0]     phase_reg;
    logic [1:0]     phase_next;
    logic           neg_reg;
    logic           neg_next;
    logic [31:0]    mag_reg;
    logic [31:0]    mag_next;
    logic           bad_reg;
    logic           bad_next;

    sdp_pkg::res_t  res_mem_reg [2];
    sdp_pkg::res_t  res_in;
    logic           res_wr_reg;
    logic           res_rd_reg;
    logic [1:0]     res_cnt_reg;
    logic [1:0]     res_cnt_next;
    logic           res_full;
    logic           res_push;
    logic           res_pop;

    logic           is_term;
    logic           tok_fire;
    logic [3:0]     last_max;
    logic           ovf;
    logic [31:0]    mag_acc;
    logic           err_now;

    // token intake
    assign res_full = (res_cnt_reg == 2'd2);
    assign is_term  = (tok.kind == sdp_pkg::KIND_TERM);
    assign tok_pop  = tok_valid && !(is_term && res_full);
    assign tok_fire = tok_pop;

    // digit accumulate with overflow check
    assign last_max = neg_reg ? sdp_pkg::LAST_MAX_NEG : sdp_pkg::LAST_MAX_POS;
    assign ovf      = (mag_reg > sdp_pkg::TENTH_LIMIT) ||
                      ((mag_reg == sdp_pkg::TENTH_LIMIT) && (tok.digit > last_max));
    assign mag_acc  = (mag_reg << 3) + (mag_reg << 1) + {28'd0, tok.digit};

    // result of a terminating byte
    assign err_now      = bad_reg || (phase_reg == PH_SPACE) || (phase_reg == PH_SIGN);
    assign res_in.error = err_now;
    assign res_in.value = err_now ? 32'd0 : (neg_reg ? (32'd0 - mag_reg) : mag_reg);
    assign res_push     = tok_fire && is_term;

    // parse state update
    always_comb
    begin
        phase_next = phase_reg;
        neg_next   = neg_reg;
        mag_next   = mag_reg;
        bad_next   = bad_reg;
        if (tok_fire)
        begin
            if (is_term)
            begin
                phase_next = PH_SPACE;
                neg_next   = 1'b0;
                mag_next   = 32'd0;
                bad_next   = 1'b0;
            end
            else if (!bad_reg)
            begin
                case (phase_reg)
                    PH_SPACE:
                    begin
                        if (tok.kind == sdp_pkg::KIND_BLANK)
                        begin
                            phase_next = PH_SPACE;
                        end
                        else if (tok.kind == sdp_pkg::KIND_PLUS ||
                                 tok.kind == sdp_pkg::KIND_MINUS)
                        begin
                            neg_next   = (tok.kind == sdp_pkg::KIND_MINUS);
                            phase_next = PH_SIGN;
                        end
                        else if (tok.kind == sdp_pkg::KIND_DIGIT)
                        begin
                            phase_next = PH_DIGITS;
                            if (ovf)
                            begin
                                bad_next = 1'b1;
                            end
                            else
                            begin
                                mag_next = mag_acc;
                            end
                        end
                        else
                        begin
                            bad_next = 1'b1;
                        end
                    end
                    PH_SIGN:
                    begin
                        if (tok.kind == sdp_pkg::KIND_DIGIT)
                        begin
                            phase_next = PH_DIGITS;
                            if (ovf)
                            begin
                                bad_next = 1'b1;
                            end
                            else
                            begin
                                mag_next = mag_acc;
                            end
                        end
                        else
                        begin
                            bad_next = 1'b1;
                        end
                    end
                    default:
                    begin
                        // digits phase, and the unused code behaves the same
                        if (tok.kind == sdp_pkg::KIND_DIGIT)
                        begin
                            if (ovf)
                            begin
                                bad_next = 1'b1;
                            end
                            else
                            begin
                                mag_next = mag_acc;
                            end
                        end
                        else
                        begin
                            bad_next = 1'b1;
                        end
                    end
                endcase
            end
        end
    end

    // result queue handshakes
    assign empty   = (res_cnt_reg == 2'd0);
    assign res_pop = pop && !empty;
    assign value   = res_mem_reg[res_rd_reg].value;
    assign error   = res_mem_reg[res_rd_reg].error;

    always_comb
    begin
        res_cnt_next = res_cnt_reg;
        if (res_push && !res_pop)
        begin
            res_cnt_next = res_cnt_reg + 2'd1;
        end
        else if (res_pop && !res_push)
        begin
            res_cnt_next = res_cnt_reg - 2'd1;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_SPACE;
            neg_reg     <= 1'b0;
            mag_reg     <= 32'd0;
            bad_reg     <= 1'b0;
            res_wr_reg  <= 1'b0;
            res_rd_reg  <= 1'b0;
            res_cnt_reg <= 2'd0;
        end
        else
        begin
            phase_reg   <= phase_next;
            neg_reg     <= neg_next;
            mag_reg     <= mag_next;
            bad_reg     <= bad_next;
            res_wr_reg  <= res_push ? ~res_wr_reg : res_wr_reg;
            res_rd_reg  <= res_pop ? ~res_rd_reg : res_rd_reg;
            res_cnt_reg <= res_cnt_next;
        end
    end

    // result storage
    always_ff @(posedge clk)
    begin
        if (res_push)
        begin
            res_mem_reg[res_wr_reg] <= res_in;
        end
    end

    // parser checks
    a_term_clears: assert property (@(posedge clk) disable iff (!rst_n)
        tok_fire && is_term |=> phase_reg == PH_SPACE && !bad_reg && mag_reg == 32'd0)
        else $error("state not cleared after terminating byte");

    a_bad_freezes: assert property (@(posedge clk) disable iff (!rst_n)
        bad_reg && !(tok_fire && is_term) |=> $stable(mag_reg) && bad_reg)
        else $error("magnitude changed after an error");

    a_mag_range: assert property (@(posedge clk) disable iff (!rst_n)
        mag_reg <= 32'd2147483648)
        else $error("magnitude beyond signed 32-bit range");

    a_res_bound: assert property (@(posedge clk) disable iff (!rst_n)
        res_cnt_reg != 2'd3)
        else $error("result queue count out of range");

endmodule

[rtl/core/strict_decimal_to_int32_parser_core.sv]
// Strict decimal string to int32 parser, top level.
// Throughput: one byte per cycle unless the token queue is full; the back end consumes
// one token per cycle, but holds a terminating token while the result queue is full.
// Bytes are parsed as they leave the two-entry token queue; a terminating byte's result
// waits in the two-entry result queue for pop, so either side can stall without loss.
// Reset (rst_n low, asynchronous) empties both queues and returns to the whitespace phase.
`timescale 1ns / 1ps

module strict_decimal_to_int32_parser_core (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    output logic               full,
    input  logic [7:0]         ch,
    output logic               empty,
    input  logic               pop,
    output logic signed [31:0] value,
    output logic               error
);

    sdp_pkg::tok_t tok;
    logic          tok_valid;
    logic          tok_pop;

    // byte classifier and token queue
    sdp_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .ch        (ch),
        .tok       (tok),
        .tok_valid (tok_valid),
        .tok_pop   (tok_pop)
    );

    // parse engine and result queue
    sdp_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .tok       (tok),
        .tok_valid (tok_valid),
        .tok_pop   (tok_pop),
        .empty     (empty),
        .pop       (pop),
        .value     (value),
        .error     (error)
    );

endmodule

[tb/strict_decimal_to_int32_parser_checker.sv]
// transfer monitor, result predictor and comparator for the strict decimal parser
`timescale 1ns / 1ps

module strict_decimal_to_int32_parser_checker (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  logic               full,
    input  logic [7:0]         ch,
    input  logic               empty,
    input  logic               pop,
    input  logic signed [31:0] value,
    input  logic               error,
    output int                 mismatches,
    output int                 outstanding,
    output int                 results_checked
);

    typedef enum logic [1:0] {
        SCAN_BLANK  = 2'd0,
        SCAN_SIGNED = 2'd1,
        SCAN_DIGITS = 2'd2
    } scan_phase_e;

    // predicted parser state
    scan_phase_e scan_phase;
    logic        neg_sign;
    logic [31:0] accum;
    logic        flawed;

    // parsed results still waiting for their transfer
    sdp_pkg::res_t parsed_results[$];
    int            miss_total;
    int            result_total;

    // fold one digit into the magnitude unless it would leave the int32 range
    task automatic add_digit(input logic [3:0] dval);
        logic [3:0] last_max;
        last_max = neg_sign ? sdp_pkg::LAST_MAX_NEG : sdp_pkg::LAST_MAX_POS;
        if (accum > sdp_pkg::TENTH_LIMIT || (accum == sdp_pkg::TENTH_LIMIT && dval > last_max))
            flawed = 1'b1;
        else
            accum = accum * 32'd10 + {28'd0, dval};
    endtask

    // advance the predicted parser by one byte
    task automatic scan_byte(input logic [7:0] c);
        logic          blank;
        logic          digit;
        sdp_pkg::res_t parsed;
        blank = (c == sdp_pkg::CH_SPACE) || (c >= sdp_pkg::CH_TAB && c <= sdp_pkg::CH_CR);
        digit = (c >= sdp_pkg::CH_ZERO) && (c <= sdp_pkg::CH_NINE);
        if (c == sdp_pkg::CH_NUL)
        begin
            parsed.error = flawed || scan_phase == SCAN_BLANK || scan_phase == SCAN_SIGNED;
            parsed.value = parsed.error ? 32'd0 : (neg_sign ? -accum : accum);
            parsed_results.push_back(parsed);
            scan_phase = SCAN_BLANK;
            neg_sign   = 1'b0;
            accum      = '0;
            flawed     = 1'b0;
        end
        else if (!flawed)
        begin
            case (scan_phase)
                SCAN_BLANK:
                begin
                    if (blank)
                        flawed = 1'b0;
                    else if (c == sdp_pkg::CH_PLUS || c == sdp_pkg::CH_MINUS)
                    begin
                        neg_sign   = (c == sdp_pkg::CH_MINUS);
                        scan_phase = SCAN_SIGNED;
                    end
                    else if (digit)
                    begin
                        scan_phase = SCAN_DIGITS;
                        add_digit(4'(c - sdp_pkg::CH_ZERO));
                    end
                    else
                        flawed = 1'b1;
                end
                SCAN_SIGNED:
                begin
                    if (digit)
                    begin
                        scan_phase = SCAN_DIGITS;
                        add_digit(4'(c - sdp_pkg::CH_ZERO));
                    end
                    else
                        flawed = 1'b1;
                end
                default:
                begin
                    if (digit)
                        add_digit(4'(c - sdp_pkg::CH_ZERO));
                    else
                        flawed = 1'b1;
                end
            endcase
        end
    endtask

    // compare a result transfer with the oldest parsed result
    task automatic check_result();
        sdp_pkg::res_t want;
        result_total++;
        if (parsed_results.size() == 0)
        begin
            miss_total++;
            if (miss_total <= 10)
                $display("unexpected result: value %0d error %0b", value, error);
        end
        else
        begin
            want = parsed_results.pop_front();
            if (value !== want.value || error !== want.error)
            begin
                miss_total++;
                if (miss_total <= 10)
                    $display("result mismatch: expected value %0d error %0b, got value %0d error %0b",
                             $signed(want.value), want.error, value, error);
            end
        end
    endtask

    // sample both channels at each edge
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            scan_phase = SCAN_BLANK;
            neg_sign   = 1'b0;
            accum      = '0;
            flawed     = 1'b0;
            parsed_results.delete();
        end
        else
        begin
            if (pop && !empty)
                check_result();
            if (push && !full)
                scan_byte(ch);
        end
        mismatches      <= miss_total;
        outstanding     <= parsed_results.size();
        results_checked <= result_total;
    end

endmodule

[tb/strict_decimal_to_int32_parser_core_tb.sv]
// stimulus, handshake pacing and verdict for the strict decimal parser
`timescale 1ns / 1ps

module strict_decimal_to_int32_parser_core_tb;

    localparam int ITEM_TARGET    = 950;
    localparam int CALM_ITEMS     = 120;
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int DRAIN_CYCLES   = 8;

    typedef enum int {SHAPE_CLEAN, SHAPE_FLAWED, SHAPE_NOISE} shape_e;
    typedef enum int {MAG_SMALL, MAG_WORD, MAG_EDGE, MAG_LONG} mag_e;
    typedef enum int {FLAW_STRAY, FLAW_SIGN, FLAW_BLANK, FLAW_NO_DIGITS} flaw_e;

    logic               clk   = 1'b0;
    logic               rst_n = 1'b0;
    logic               push  = 1'b0;
    logic               pop   = 1'b0;
    logic [7:0]         ch    = 8'd0;
    logic               full;
    logic               empty;
    logic signed [31:0] value;
    logic               error;

    int                 mismatches;
    int                 outstanding;
    int                 results_checked;

    logic [7:0]         text_q[$];
    int                 bytes_sent   = 0;
    int                 strings_sent = 0;
    int                 push_idle_odds = 0;
    int                 pop_stall_odds = 0;
    int                 pop_hold = 0;
    int                 idle_cycles = 0;
    bit                 calm = 1'b0;

    strict_decimal_to_int32_parser_core i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .full  (full),
        .ch    (ch),
        .empty (empty),
        .pop   (pop),
        .value (value),
        .error (error)
    );

    strict_decimal_to_int32_parser_checker i_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .push            (push),
        .full            (full),
        .ch              (ch),
        .empty           (empty),
        .pop             (pop),
        .value           (value),
        .error           (error),
        .mismatches      (mismatches),
        .outstanding     (outstanding),
        .results_checked (results_checked)
    );

    // clock
    always #5 clk = ~clk;

    // result side: pop with random stall bursts, always ready when calm
    always @(posedge clk)
    begin
        if (calm)
            pop <= 1'b1;
        else if (pop_hold > 0)
        begin
            pop      <= 1'b0;
            pop_hold <= pop_hold - 1;
        end
        else if ($urandom_range(0, 9) < pop_stall_odds)
        begin
            pop      <= 1'b0;
            pop_hold <= $urandom_range(0, 2);
        end
        else
            pop <= 1'b1;
    end

    // watchdog on cycles without any transfer
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((push && !full) || (pop && !empty))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("Verification failed");
                $finish;
            end
        end
    end

    // one byte transfer
    task automatic send_byte(input logic [7:0] b);
        push <= 1'b1;
        ch   <= b;
        @(posedge clk);
        while (full)
            @(posedge clk);
        bytes_sent++;
    endtask

    // send the queued string, idling between bytes at random
    task automatic send_string();
        foreach (text_q[i])
        begin
            send_byte(text_q[i]);
            if (!calm && $urandom_range(0, 9) < push_idle_odds)
            begin
                push <= 1'b0;
                repeat ($urandom_range(1, 3))
                    @(posedge clk);
            end
        end
        strings_sent++;
    endtask

    // space or one of the control codes tab through carriage return
    function automatic logic [7:0] pick_blank();
        int r;
        r = $urandom_range(8, 13);
        return (r == 8) ? sdp_pkg::CH_SPACE : 8'(r);
    endfunction

    // whitespace, optional sign and a digit run
    task automatic build_number();
        longint unsigned mag;
        string           digits;
        mag_e            kind;
        repeat ($urandom_range(0, 3) == 0 ? $urandom_range(1, 3) : 0)
            text_q.push_back(pick_blank());
        case ($urandom_range(0, 2))
            0: text_q.push_back(sdp_pkg::CH_PLUS);
            1: text_q.push_back(sdp_pkg::CH_MINUS);
            default: ;
        endcase
        if ($urandom_range(0, 7) == 0)
            repeat ($urandom_range(1, 2))
                text_q.push_back(sdp_pkg::CH_ZERO);
        kind = mag_e'($urandom_range(0, 3));
        case (kind)
            MAG_SMALL: mag = $urandom_range(0, 999);
            MAG_WORD:  mag = {32'd0, $urandom};
            MAG_EDGE:  mag = 64'd2147483640 + $urandom_range(0, 19);
            default:   mag = 0;
        endcase
        if (kind == MAG_LONG)
            repeat ($urandom_range(10, 13))
                text_q.push_back(sdp_pkg::CH_ZERO + 8'($urandom_range(0, 9)));
        else
        begin
            digits = $sformatf("%0d", mag);
            for (int i = 0; i < digits.len(); i++)
                text_q.push_back(digits[i]);
        end
    endtask

    // damage a well-formed number in one way
    task automatic add_flaw();
        flaw_e flaw;
        flaw = flaw_e'($urandom_range(0, 3));
        case (flaw)
            FLAW_STRAY:
                text_q.insert($urandom_range(0, text_q.size()), 8'($urandom_range(1, 255)));
            FLAW_SIGN:
                text_q.insert($urandom_range(0, text_q.size()),
                              $urandom_range(0, 1) ? sdp_pkg::CH_PLUS : sdp_pkg::CH_MINUS);
            FLAW_BLANK:
                text_q.insert($urandom_range(1, text_q.size()), pick_blank());
            default:
                while (text_q.size() > 0 && text_q[text_q.size() - 1] >= sdp_pkg::CH_ZERO &&
                       text_q[text_q.size() - 1] <= sdp_pkg::CH_NINE)
                    void'(text_q.pop_back());
        endcase
    endtask

    // main sequence
    initial
    begin
        shape_e shape;
        int     r;

        repeat (3)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty, blanks only, lone sign, blank after sign, negative zero,
        // blank after digits, stray high bytes then ignored digit, sign after digits,
        // second sign
        text_q = '{sdp_pkg::CH_NUL};
        send_string();
        text_q = '{sdp_pkg::CH_SPACE, sdp_pkg::CH_CR, sdp_pkg::CH_NUL};
        send_string();
        text_q = '{sdp_pkg::CH_MINUS, sdp_pkg::CH_NUL};
        send_string();
        text_q = '{sdp_pkg::CH_PLUS, sdp_pkg::CH_SPACE, sdp_pkg::CH_NUL};
        send_string();
        text_q = '{sdp_pkg::CH_TAB, sdp_pkg::CH_MINUS, sdp_pkg::CH_ZERO, sdp_pkg::CH_NUL};
        send_string();
        text_q = '{sdp_pkg::CH_ZERO + 8'd7, sdp_pkg::CH_SPACE, sdp_pkg::CH_NUL};
        send_string();
        text_q = '{8'hFF, 8'h80, sdp_pkg::CH_ZERO + 8'd1, sdp_pkg::CH_NUL};
        send_string();
        text_q = '{sdp_pkg::CH_NINE, sdp_pkg::CH_PLUS, sdp_pkg::CH_NUL};
        send_string();
        text_q = '{sdp_pkg::CH_PLUS, sdp_pkg::CH_MINUS,
                   sdp_pkg::CH_ZERO + 8'd5, sdp_pkg::CH_NUL};
        send_string();

        // random strings: mostly clean numbers, some damaged, some noise
        while (bytes_sent < ITEM_TARGET)
        begin
            calm = (bytes_sent >= ITEM_TARGET - CALM_ITEMS);
            push_idle_odds = calm ? 0 : $urandom_range(0, 3);
            pop_stall_odds = calm ? 0 : $urandom_range(0, 4);
            r = $urandom_range(0, 99);
            shape = (r < 70) ? SHAPE_CLEAN : (r < 85) ? SHAPE_FLAWED : SHAPE_NOISE;
            text_q.delete();
            if (shape == SHAPE_NOISE)
                repeat ($urandom_range(0, 6))
                    text_q.push_back(8'($urandom_range(1, 255)));
            else
            begin
                build_number();
                if (shape == SHAPE_FLAWED)
                    add_flaw();
            end
            text_q.push_back(sdp_pkg::CH_NUL);
            send_string();
        end
        push <= 1'b0;
        calm = 1'b1;

        // drain the remaining results, then allow for the pipeline latency
        do
            @(posedge clk);
        while (outstanding != 0);
        repeat (DRAIN_CYCLES)
            @(posedge clk);

        $display("%0d strings (%0d bytes) sent, %0d results checked", strings_sent,
                 bytes_sent, results_checked);
        $display("covered clean, boundary, overflowing, damaged and noise strings with stalls");
        if (mismatches == 0 && outstanding == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
